FILE: hw/rtl/arithmetic_series_range_select_defines.svh
// Assertion helpers for the arithmetic series range select block.
`ifndef ARITHMETIC_SERIES_RANGE_SELECT_DEFINES_SVH
`define ARITHMETIC_SERIES_RANGE_SELECT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ASRS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("range select check failed");

// Next-cycle implication, checked outside reset.
`define ASRS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("range select check failed");

`endif

FILE: hw/rtl/asrs_pkg.sv
package asrs_pkg;

   localparam int DW        = 32;
   localparam int DIV_STEPS = DW;

   localparam logic [1:0] REG_FIRST = 2'd0;
   localparam logic [1:0] REG_LAST  = 2'd1;
   localparam logic [1:0] REG_STEP  = 2'd2;

   typedef struct packed {
      logic bad;
      logic pos;
      logic lnull;
      logic hnull;
      logic li;
      logic hi;
      logic anti;
      logic lneg;
      logic hneg;
   } info_type;

   // remainder and the shifting numerator / quotient word
   typedef struct packed {
      logic [DW-1:0] rem;
      logic [DW-1:0] qn;
   } div_type;

   typedef struct packed {
      info_type      info;
      logic [DW-1:0] dsor;
      div_type       dn;
      div_type       dl;
      div_type       dh;
   } work_type;

   typedef struct packed {
      info_type    info;
      logic [DW:0] n;
      logic [DW:0] o1;
      logic [DW:0] o2;
   } fin_type;

   // one restoring division step: bring down a numerator bit, trial subtract
   function automatic div_type div_step(input div_type x, input logic [DW-1:0] d);
      logic [DW:0] trial;
      logic        ge;
      div_type     y;
      trial = {x.rem, x.qn[DW-1]};
      ge    = (trial >= {1'b0, d});
      y.rem = ge ? DW'(trial - {1'b0, d}) : DW'(trial);
      y.qn  = {x.qn[DW-2:0], ge};
      return y;
   endfunction

endpackage

FILE: hw/rtl/arithmetic_series_range_select.sv
// Range selection over a configured arithmetic series.
// csr_ channel: write series_first (index 0), series_last (1), series_step (2);
//   csr_ready is always high, other indexes are dropped. Write only when idle.
// req_ channel: one request per accepted beat; tdata = {high_bound, low_bound},
//   tuser = null, inclusive and anti flags.
// rsp_ channel: one result per request, in order; tdata = {series_length,
//   end_index, first_index}, tuser = {bad_series, complement}.
// Structure: the three quotients (series length, lower and upper bound index) run
//   in three restoring dividers that retire one quotient bit per pipeline stage,
//   32 stages deep, with one setup stage before and one index fixup stage plus
//   one clamp and output stage after.
// Throughput: one request per cycle when the receiver keeps rsp_tready high.
// Stall: when rsp_tvalid is high and rsp_tready low, the whole pipeline holds
//   and req_tready drops in the same cycle; nothing is lost or repeated.
// Reset: clears all valid bits and loads first=0, last=0, step=1.
module arithmetic_series_range_select
   import asrs_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] low_bound, [63:32] high_bound
   input  logic [63:0]  req_tdata,
   // [0] low_is_null, [1] high_is_null, [2] low_inclusive, [3] high_inclusive,
   // [4] anti_select
   input  logic [4:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] first_index, [63:32] end_index, [95:64] series_length
   output logic [95:0]  rsp_tdata,
   // [0] complement, [1] bad_series
   output logic [1:0]   rsp_tuser
);

`include "arithmetic_series_range_select_defines.svh"

   localparam int EW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

   // wrap a register or bound to the value width and sign-extend
   function automatic logic signed [DW:0] wrap(input logic [31:0] x);
      return (DW+1)'($signed(x[EW-1:0]));
   endfunction

   logic [31:0] first_ff, last_ff, step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= '0;
         step_ff  <= 32'd1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FIRST: first_ff <= csr_data;
            REG_LAST:  last_ff  <= csr_data;
            REG_STEP:  step_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline advances together; hold everything on a stalled result
   logic adv;
   logic out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- setup stage: signs, differences, divisor magnitude
   logic signed [DW:0] f_v, l_v, s_v, lo_v, hb_v, dn_v, dl_v, dh_v;
   work_type           setup_in;

   always_comb begin
      f_v  = wrap(first_ff);
      l_v  = wrap(last_ff);
      s_v  = wrap(step_ff);
      lo_v = wrap(req_tdata[31:0]);
      hb_v = wrap(req_tdata[63:32]);
      setup_in.info.pos   = (s_v > 0);
      setup_in.info.bad   = (s_v == 0) || ((s_v > 0) && (f_v > l_v)) ||
                            ((s_v < 0) && (f_v < l_v));
      setup_in.info.lnull = req_tuser[0];
      setup_in.info.hnull = req_tuser[1];
      setup_in.info.li    = req_tuser[2];
      setup_in.info.hi    = req_tuser[3];
      setup_in.info.anti  = req_tuser[4];
      dn_v = setup_in.info.pos ? (l_v - f_v) : (f_v - l_v);
      dl_v = setup_in.info.pos ? (lo_v - f_v) : (f_v - lo_v);
      dh_v = setup_in.info.pos ? (hb_v - f_v) : (f_v - hb_v);
      setup_in.info.lneg = dl_v[DW];
      setup_in.info.hneg = dh_v[DW];
      setup_in.dsor   = s_v[DW] ? DW'(-s_v) : DW'(s_v);
      setup_in.dn.rem = '0;
      setup_in.dn.qn  = dn_v[DW] ? '0 : dn_v[DW-1:0];
      setup_in.dl.rem = '0;
      setup_in.dl.qn  = dl_v[DW] ? '0 : dl_v[DW-1:0];
      setup_in.dh.rem = '0;
      setup_in.dh.qn  = dh_v[DW] ? '0 : dh_v[DW-1:0];
   end

   work_type pipe_ff  [0:DIV_STEPS];
   logic     valid_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff[0] <= setup_in;
      end
   end

   // ---------------- divider stages: one quotient bit per stage
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      work_type step_in;
      always_comb begin
         step_in    = pipe_ff[g];
         step_in.dn = div_step(pipe_ff[g].dn, pipe_ff[g].dsor);
         step_in.dl = div_step(pipe_ff[g].dl, pipe_ff[g].dsor);
         step_in.dh = div_step(pipe_ff[g].dh, pipe_ff[g].dsor);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[g+1] <= valid_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            pipe_ff[g+1] <= step_in;
         end
      end
   end

   // ---------------- fixup stage: round quotients into raw indexes
   work_type    w;
   fin_type     fin_in, fin_ff;
   logic        fin_valid_ff;
   logic [DW:0] q_lo, q_hi;

   always_comb begin
      w           = pipe_ff[DIV_STEPS];
      fin_in.info = w.info;
      fin_in.n    = {1'b0, w.dn.qn} + (DW+1)'(w.dn.rem != '0);
      q_lo = {1'b0, w.dl.qn} +
             (DW+1)'((w.dl.rem != '0) || (w.info.pos ? !w.info.li : w.info.li));
      q_hi = {1'b0, w.dh.qn} +
             (DW+1)'((w.dh.rem != '0) || (w.info.pos ? w.info.hi : !w.info.hi));
      if (w.info.pos) begin
         fin_in.o1 = (w.info.lnull || w.info.lneg) ? '0 : q_lo;
         fin_in.o2 = w.info.hnull ? fin_in.n : (w.info.hneg ? '0 : q_hi);
      end else begin
         fin_in.o2 = w.info.lnull ? fin_in.n : (w.info.lneg ? '0 : q_lo);
         fin_in.o1 = (w.info.hnull || w.info.hneg) ? '0 : q_hi;
      end
      if (w.info.lnull && w.info.hnull) begin
         fin_in.o1 = '0;
         fin_in.o2 = (w.info.li && w.info.hi && !w.info.anti) ? '0 : fin_in.n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   // ---------------- output stage: clamp to n, empty anti range widens, bad series zeroes
   logic [DW:0]   c1, c2;
   logic          comp;
   logic [95:0]   data_in, data_ff;
   logic [1:0]    user_in, user_ff;

   always_comb begin
      c1   = (fin_ff.o1 > fin_ff.n) ? fin_ff.n : fin_ff.o1;
      c2   = (fin_ff.o2 > fin_ff.n) ? fin_ff.n : fin_ff.o2;
      c1   = (c1 > c2) ? c2 : c1;
      comp = fin_ff.info.anti;
      if (comp && (c1 == c2)) begin
         c1   = '0;
         c2   = fin_ff.n;
         comp = 1'b0;
      end
      data_in = {fin_ff.n[DW-1:0], c2[DW-1:0], c1[DW-1:0]};
      user_in = {1'b0, comp};
      if (fin_ff.info.bad) begin
         data_in = '0;
         user_in = 2'b10;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

   // ---------------- checks
   `ASRS_ASSERT_NOW(a_bad_zeroes, rsp_tvalid && rsp_tuser[1],
      (rsp_tdata == '0) && !rsp_tuser[0])
   `ASRS_ASSERT_NOW(a_range_order, rsp_tvalid,
      (rsp_tdata[31:0] <= rsp_tdata[63:32]) && (rsp_tdata[63:32] <= rsp_tdata[95:64]))
   `ASRS_ASSERT_NOW(a_comp_nonempty, rsp_tvalid && rsp_tuser[0],
      rsp_tdata[31:0] != rsp_tdata[63:32])
   `ASRS_ASSERT_NEXT(a_stall_holds, !adv,
      $stable(valid_ff[0]) && $stable(fin_valid_ff) && $stable(rsp_tdata))

endmodule
